>>> design/gdcr_pkg.sv
// gdcr_pkg: shared types, register indexes and constants of the grid dda column raycaster
// no dependencies; used by gdcr_alu, the top level and gdcr_checker
`default_nettype none

package gdcr_pkg;

  localparam int CFG_IW = 4;
  localparam int CFG_DW = 21;

  localparam logic [CFG_IW-1:0] REG_CAMERA_X     = 4'd0;
  localparam logic [CFG_IW-1:0] REG_CAMERA_Y     = 4'd1;
  localparam logic [CFG_IW-1:0] REG_VIEW_DIR_X   = 4'd2;
  localparam logic [CFG_IW-1:0] REG_VIEW_DIR_Y   = 4'd3;
  localparam logic [CFG_IW-1:0] REG_LENS_PLANE_X = 4'd4;
  localparam logic [CFG_IW-1:0] REG_LENS_PLANE_Y = 4'd5;
  localparam logic [CFG_IW-1:0] REG_SCREEN_W     = 4'd6;
  localparam logic [CFG_IW-1:0] REG_SCREEN_H     = 4'd7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [2:0] WALL_RED    = 3'd1;
  localparam logic [2:0] WALL_GREEN  = 3'd2;
  localparam logic [2:0] WALL_BLUE   = 3'd3;
  localparam logic [2:0] WALL_VIOLET = 3'd4;

  // shared unit operand widths
  localparam int ALU_AW   = 41;  // multiplicand / dividend
  localparam int ALU_BW   = 31;  // multiplier / divisor
  localparam int ALU_RW   = 58;  // product
  localparam int MUL_BITS = 17;
  localparam int DIV_BITS = 31;

  typedef struct packed {
    logic       cmd;
    logic [11:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] cell_code;
  } in_item_t;

  typedef struct packed {
    logic [11:0] draw_start;
    logic [11:0] draw_end;
    logic [2:0]  wall_code;
    logic        hit_side;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [21:0] wall_distance;
    logic        left_map;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic logic [23:0] wall_rgb(input logic [2:0] code);
    logic [23:0] rgb;
    case (code)
      WALL_RED:    rgb = {8'd255, 8'd0,   8'd0};
      WALL_GREEN:  rgb = {8'd0,   8'd255, 8'd0};
      WALL_BLUE:   rgb = {8'd0,   8'd0,   8'd255};
      WALL_VIOLET: rgb = {8'd166, 8'd77,  8'd255};
      default:     rgb = {8'd255, 8'd0,   8'd255};
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

>>> design/gdcr_ram.sv
// gdcr_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module gdcr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/gdcr_alu.sv
// gdcr_alu: shared bit-serial unit, shift-add multiply or restoring divide
// depends on gdcr_pkg
`default_nettype none

module gdcr_alu (
  input  wire                         clk,
  input  wire                         rst_n,
  input  gdcr_pkg::alu_req_t          req,
  input  wire [gdcr_pkg::ALU_AW-1:0]  opa,
  input  wire [gdcr_pkg::ALU_BW-1:0]  opb,
  output gdcr_pkg::alu_stat_t         stat,
  output logic [gdcr_pkg::ALU_RW-1:0] result
);

  logic                         busy_r, done_r, div_r;
  logic [4:0]                   cnt_r;
  logic [gdcr_pkg::ALU_RW-1:0]  acc_r, mcand_r;
  logic [gdcr_pkg::MUL_BITS-1:0] mplier_r;
  logic [gdcr_pkg::ALU_BW:0]    rem_r;
  logic [gdcr_pkg::ALU_BW-1:0]  quo_r, den_r;
  logic [gdcr_pkg::ALU_BW:0]    trial;
  logic                         fits;

  assign trial = {rem_r[gdcr_pkg::ALU_BW-1:0], quo_r[gdcr_pkg::ALU_BW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.is_div ? 5'(gdcr_pkg::DIV_BITS) : 5'(gdcr_pkg::MUL_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r    <= req.is_div;
      acc_r    <= '0;
      mcand_r  <= gdcr_pkg::ALU_RW'(opa);
      mplier_r <= opb[gdcr_pkg::MUL_BITS-1:0];
      rem_r    <= '0;
      quo_r    <= opa[gdcr_pkg::ALU_BW-1:0];
      den_r    <= opb;
    end else if (busy_r) begin
      if (div_r) begin
        rem_r <= fits ? trial - {1'b0, den_r} : trial;
        quo_r <= {quo_r[gdcr_pkg::ALU_BW-2:0], fits};
      end else begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[gdcr_pkg::ALU_RW-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[gdcr_pkg::MUL_BITS-1:1]};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = div_r ? gdcr_pkg::ALU_RW'(quo_r) : acc_r;

endmodule

`default_nettype wire

>>> design/grid_dda_column_raycaster_unit.sv
// grid_dda_column_raycaster_unit: top level, sequencer, dda walk and map store
// depends on gdcr_pkg, gdcr_ram, gdcr_alu
`default_nettype none

// The block holds a MAP_SIZE x MAP_SIZE map of 3-bit wall codes and takes one
// beat at a time on the input channel. A write beat (cmd 0) stores one cell
// and gives no result; a write outside the map is dropped. A cast beat (cmd 1)
// gives exactly one result beat: the ray for the column is built and walked
// cell by cell until a nonzero cell, the map edge or the step limit is met.
// All multiplies and divides run through one bit-serial unit: the column
// scale is a divide, each ray component a multiply, each delta a divide,
// each first side distance a multiply and the line height a divide; each
// grid step that stays in the map passes through a step state and a map
// check state, at most 4*MAP_SIZE+4 steps. After reset the map is cleared
// by a pass over every cell during which no beat is accepted; configuration
// writes are taken at any time but must only be issued while the block is
// idle. A finished result is held in an output register, and write beats
// are still taken while it waits.
module grid_dda_column_raycaster_unit #(
  parameter int MAP_SIZE = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  gdcr_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output gdcr_pkg::out_item_t          out_data,
  input  wire                          cfg_we,
  input  wire [gdcr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [gdcr_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int DEPTH      = MAP_SIZE * MAP_SIZE;
  localparam int AW         = $clog2(DEPTH);
  localparam int STEP_LIMIT = 4 * MAP_SIZE + 4;
  localparam int SW         = $clog2(STEP_LIMIT + 1);

  // sequencer codes
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CAM   = 4'd2;
  localparam logic [3:0] S_RX    = 4'd3;
  localparam logic [3:0] S_RY    = 4'd4;
  localparam logic [3:0] S_DX    = 4'd5;
  localparam logic [3:0] S_DY    = 4'd6;
  localparam logic [3:0] S_SX    = 4'd7;
  localparam logic [3:0] S_SY    = 4'd8;
  localparam logic [3:0] S_STEP  = 4'd9;
  localparam logic [3:0] S_CHECK = 4'd10;
  localparam logic [3:0] S_DIST  = 4'd11;
  localparam logic [3:0] S_LINE  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [40:0] DELTA_INF = 41'h100_0000_0000;

  // configuration registers
  logic [20:0]        cam_x_r, cam_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [11:0]        width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= 21'd786432;
      cam_y_r   <= 21'd524288;
      dir_x_r   <= -16'sd16384;
      dir_y_r   <= 16'sd0;
      plane_x_r <= 16'sd0;
      plane_y_r <= 16'sd10813;
      width_r   <= 12'd1280;
      height_r  <= 12'd720;
    end else if (cfg_we) begin
      case (cfg_index)
        gdcr_pkg::REG_CAMERA_X:     cam_x_r   <= cfg_wdata;
        gdcr_pkg::REG_CAMERA_Y:     cam_y_r   <= cfg_wdata;
        gdcr_pkg::REG_VIEW_DIR_X:   dir_x_r   <= cfg_wdata[15:0];
        gdcr_pkg::REG_VIEW_DIR_Y:   dir_y_r   <= cfg_wdata[15:0];
        gdcr_pkg::REG_LENS_PLANE_X: plane_x_r <= cfg_wdata[15:0];
        gdcr_pkg::REG_LENS_PLANE_Y: plane_y_r <= cfg_wdata[15:0];
        gdcr_pkg::REG_SCREEN_W:     width_r   <= cfg_wdata[11:0];
        gdcr_pkg::REG_SCREEN_H:     height_r  <= cfg_wdata[11:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // zero screen size acts as one
  logic [11:0] w_eff, h_eff;
  assign w_eff = (width_r == 12'd0) ? 12'd1 : width_r;
  assign h_eff = (height_r == 12'd0) ? 12'd1 : height_r;

  // sequencer and cast state
  logic [3:0]          state_r;
  logic                issued_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [11:0]         col_r;
  logic                cam_neg_r;
  logic [27:0]         cam_mag_r;
  logic                rx_neg_r, ry_neg_r;
  logic [30:0]         rx_mag_r, ry_mag_r;
  logic [40:0]         dx_r, dy_r;
  logic [49:0]         sdx_r, sdy_r;
  logic signed [6:0]   mx_r, my_r;
  logic                side_r, left_r;
  logic [2:0]          code_r;
  logic [SW-1:0]       steps_r;
  logic [21:0]         dist_r;
  logic [32:0]         line_r;
  logic                out_valid_r;
  gdcr_pkg::out_item_t out_data_r;

  // shared unit
  gdcr_pkg::alu_req_t  alu_req;
  gdcr_pkg::alu_stat_t alu_stat;
  logic [gdcr_pkg::ALU_AW-1:0] alu_a;
  logic [gdcr_pkg::ALU_BW-1:0] alu_b;
  logic [gdcr_pkg::ALU_RW-1:0] alu_res;

  gdcr_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .stat   (alu_stat),
    .result (alu_res)
  );

  // ray component from the view direction plus the product plane*cam
  logic               sel_y;
  logic signed [15:0] cur_plane, cur_dir;
  logic [15:0]        plane_abs;
  logic               prod_neg;
  logic [44:0]        prod_mag;
  logic signed [44:0] prod_s;
  logic signed [31:0] ray_s;
  logic [31:0]        ray_abs;

  assign sel_y     = (state_r == S_RY);
  assign cur_plane = sel_y ? plane_y_r : plane_x_r;
  assign cur_dir   = sel_y ? dir_y_r : dir_x_r;
  assign plane_abs = cur_plane[15] ? (~cur_plane + 16'd1) : cur_plane;
  assign prod_neg  = cam_neg_r ^ cur_plane[15];
  assign prod_mag  = {1'b0, alu_res[43:0]};
  assign prod_s    = prod_neg ? -signed'(prod_mag) : signed'(prod_mag);
  // floor division by 2^14 is an arithmetic shift
  assign ray_s     = 32'(prod_s >>> 14) + 32'(cur_dir);
  assign ray_abs   = ray_s[31] ? -ray_s : ray_s;

  // first side distance fraction
  logic [16:0] frac_x, frac_y;
  assign frac_x = rx_neg_r ? {1'b0, cam_x_r[15:0]} : 17'd65536 - {1'b0, cam_x_r[15:0]};
  assign frac_y = ry_neg_r ? {1'b0, cam_y_r[15:0]} : 17'd65536 - {1'b0, cam_y_r[15:0]};

  // operand selection for the shared unit
  logic op_state, op_skip;
  always_comb begin
    alu_a          = '0;
    alu_b          = '0;
    alu_req.is_div = 1'b1;
    op_state       = 1'b1;
    op_skip        = 1'b0;
    case (state_r)
      S_CAM: begin
        alu_a = gdcr_pkg::ALU_AW'({col_r, 15'd0});
        alu_b = gdcr_pkg::ALU_BW'(w_eff);
      end
      S_RX, S_RY: begin
        alu_req.is_div = 1'b0;
        alu_a = gdcr_pkg::ALU_AW'(cam_mag_r);
        alu_b = gdcr_pkg::ALU_BW'(plane_abs);
      end
      S_DX: begin
        alu_a   = 41'h4000_0000;
        alu_b   = rx_mag_r;
        op_skip = (rx_mag_r == '0);
      end
      S_DY: begin
        alu_a   = 41'h4000_0000;
        alu_b   = ry_mag_r;
        op_skip = (ry_mag_r == '0);
      end
      S_SX: begin
        alu_req.is_div = 1'b0;
        alu_a = dx_r;
        alu_b = gdcr_pkg::ALU_BW'(frac_x);
      end
      S_SY: begin
        alu_req.is_div = 1'b0;
        alu_a = dy_r;
        alu_b = gdcr_pkg::ALU_BW'(frac_y);
      end
      S_LINE: begin
        alu_a   = gdcr_pkg::ALU_AW'({h_eff, 16'd0});
        alu_b   = gdcr_pkg::ALU_BW'(dist_r);
        op_skip = (dist_r == '0);
      end
      default: op_state = 1'b0;
    endcase
    alu_req.start = op_state && !op_skip && !issued_r;
  end

  // dda step: advance the axis with the smaller side distance, y on a tie
  logic              step_y;
  logic signed [6:0] nx, ny;
  logic              in_map;
  logic [11:0]       walk_idx;
  assign step_y   = !(sdx_r < sdy_r);
  assign nx       = step_y ? mx_r : (rx_neg_r ? mx_r - 7'sd1 : mx_r + 7'sd1);
  assign ny       = step_y ? (ry_neg_r ? my_r - 7'sd1 : my_r + 7'sd1) : my_r;
  assign in_map   = !nx[6] && (nx[5:0] < 6'(MAP_SIZE)) && !ny[6] && (ny[5:0] < 6'(MAP_SIZE));
  assign walk_idx = 12'(nx[5:0]) * 12'(MAP_SIZE) + 12'(ny[5:0]);

  // map store, cleared by a pass after reset
  logic          in_acc, wr_item, wr_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2:0]    ram_wdata, ram_rdata;
  logic [11:0]   wr_idx;

  assign in_acc  = in_valid && in_ready;
  assign wr_item = in_acc && (in_data.cmd == gdcr_pkg::CMD_WRITE);
  assign wr_ok   = ({1'b0, in_data.cell_x} < 6'(MAP_SIZE)) &&
                   ({1'b0, in_data.cell_y} < 6'(MAP_SIZE));
  assign wr_idx  = 12'(in_data.cell_x) * 12'(MAP_SIZE) + 12'(in_data.cell_y);

  assign ram_we    = (state_r == S_CLEAR) || (wr_item && wr_ok);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : wr_idx[AW-1:0];
  assign ram_wdata = (state_r == S_CLEAR) ? 3'd0 : in_data.cell_code;
  assign ram_raddr = walk_idx[AW-1:0];

  gdcr_ram #(
    .WIDTH (3),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // perpendicular distance, saturated
  logic [49:0] dist_raw;
  assign dist_raw = side_r ? sdy_r - 50'(dy_r) : sdx_r - 50'(dx_r);

  // wall slice rows and colour
  logic [10:0] half_h;
  logic [31:0] half_line;
  logic [32:0] end_sum;
  logic [11:0] start_row, end_row;
  logic [23:0] rgb;
  logic        load_out;
  assign half_h    = h_eff[11:1];
  assign half_line = line_r[32:1];
  assign end_sum   = 33'(half_line) + 33'(half_h);
  assign start_row = (half_line < 32'(half_h)) ? 12'(half_h - half_line[10:0]) : 12'd0;
  assign end_row   = (end_sum > 33'(h_eff - 12'd1)) ? h_eff - 12'd1 : end_sum[11:0];
  assign rgb       = gdcr_pkg::wall_rgb(code_r);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign in_ready = (state_r == S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      issued_r    <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (alu_req.start) begin
        issued_r <= 1'b1;
      end
      if (alu_stat.done) begin
        issued_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && in_data.cmd == gdcr_pkg::CMD_CAST) begin
            state_r <= S_CAM;
          end
        end
        S_CAM, S_RX, S_RY, S_SX: begin
          if (alu_stat.done) begin
            state_r <= state_r + 4'd1;
          end
        end
        S_DX, S_DY, S_LINE: begin
          if (op_skip || alu_stat.done) begin
            state_r <= state_r + 4'd1;
          end
        end
        S_SY: begin
          if (alu_stat.done) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          state_r <= in_map ? S_CHECK : S_DIST;
        end
        S_CHECK: begin
          if (ram_rdata != 3'd0 || steps_r == SW'(STEP_LIMIT)) begin
            state_r <= S_DIST;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DIST: state_r <= S_LINE;
        S_FIN: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_data.cmd == gdcr_pkg::CMD_CAST) begin
      col_r   <= in_data.column;
      mx_r    <= 7'(cam_x_r[20:16]);
      my_r    <= 7'(cam_y_r[20:16]);
      side_r  <= 1'b0;
      left_r  <= 1'b0;
      code_r  <= 3'd0;
      steps_r <= '0;
    end
    case (state_r)
      S_CAM: begin
        // cam = 2*column*2^14/W - 2^14, kept as sign and magnitude
        if (alu_stat.done) begin
          cam_neg_r <= (alu_res[26:0] < 27'd16384);
          cam_mag_r <= (alu_res[26:0] < 27'd16384) ? 28'(27'd16384 - alu_res[26:0])
                                                   : 28'(alu_res[26:0] - 27'd16384);
        end
      end
      S_RX: begin
        if (alu_stat.done) begin
          rx_neg_r <= ray_s[31];
          rx_mag_r <= ray_abs[30:0];
        end
      end
      S_RY: begin
        if (alu_stat.done) begin
          ry_neg_r <= ray_s[31];
          ry_mag_r <= ray_abs[30:0];
        end
      end
      S_DX: begin
        if (op_skip) begin
          dx_r <= DELTA_INF;
        end else if (alu_stat.done) begin
          dx_r <= alu_res[40:0];
        end
      end
      S_DY: begin
        if (op_skip) begin
          dy_r <= DELTA_INF;
        end else if (alu_stat.done) begin
          dy_r <= alu_res[40:0];
        end
      end
      S_SX: begin
        if (alu_stat.done) begin
          sdx_r <= 50'(alu_res[57:16]);
        end
      end
      S_SY: begin
        if (alu_stat.done) begin
          sdy_r <= 50'(alu_res[57:16]);
        end
      end
      S_STEP: begin
        if (step_y) begin
          sdy_r <= sdy_r + 50'(dy_r);
        end else begin
          sdx_r <= sdx_r + 50'(dx_r);
        end
        mx_r    <= nx;
        my_r    <= ny;
        side_r  <= step_y;
        steps_r <= steps_r + SW'(1);
        // leaving the map counts as a hit with no wall code
        if (!in_map) begin
          left_r <= 1'b1;
          code_r <= 3'd0;
        end
      end
      S_CHECK: begin
        code_r <= ram_rdata;
        if (ram_rdata == 3'd0 && steps_r == SW'(STEP_LIMIT)) begin
          left_r <= 1'b1;
        end
      end
      S_DIST: begin
        dist_r <= (dist_raw > 50'(22'h3F_FFFF)) ? 22'h3F_FFFF : dist_raw[21:0];
      end
      S_LINE: begin
        // zero distance gives a saturated line height
        if (op_skip) begin
          line_r <= 33'h1_0000_0000;
        end else if (alu_stat.done) begin
          line_r <= 33'(alu_res[27:0]);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r.draw_start    <= start_row;
      out_data_r.draw_end      <= end_row;
      out_data_r.wall_code     <= code_r;
      out_data_r.hit_side      <= side_r;
      // y-side walls are drawn at half intensity
      out_data_r.red           <= side_r ? {1'b0, rgb[23:17]} : rgb[23:16];
      out_data_r.green         <= side_r ? {1'b0, rgb[15:9]}  : rgb[15:8];
      out_data_r.blue          <= side_r ? {1'b0, rgb[7:1]}   : rgb[7:0];
      out_data_r.wall_distance <= dist_r;
      out_data_r.left_map      <= left_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> design/gdcr_checker.sv
// gdcr_checker: port-level assertions for the raycaster top level, with its bind
// depends on gdcr_pkg and grid_dda_column_raycaster_unit
`default_nettype none

module gdcr_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input gdcr_pkg::out_item_t out_data
);

  // map clear pass follows reset, so no beat is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("beat taken during map clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_slice_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.draw_start <= out_data.draw_end)
    else $error("wall slice start below end");

  a_left_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.left_map |-> out_data.wall_code == 3'd0)
    else $error("wall code set on a walk that left the map");

  a_side_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_side |->
      !out_data.red[7] && !out_data.green[7] && !out_data.blue[7])
    else $error("y-side colour not halved");

endmodule

bind grid_dda_column_raycaster_unit gdcr_checker u_gdcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
